[hdl/isfir_pkg.sv]
// Shared types and constants for the interleaved stereo FIR filter.
package isfir_pkg;

   localparam int SAMPLE_W           = 16;
   localparam int COEFF_W            = 16;
   localparam int INDEX_W            = 6;
   localparam int TAPS_W             = 7;
   localparam int PRODUCT_W          = SAMPLE_W + COEFF_W;
   localparam int FRAC_BITS          = 15;
   localparam int TAPS_RESET_DEFAULT = 64;
   localparam int SAT_MAX            = 32767;
   localparam int SAT_MIN            = -32768;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_COEFF  = 1'b1;

   typedef struct packed {
      logic                       kind;
      logic signed [SAMPLE_W-1:0] sample;
      logic [INDEX_W-1:0]         coeff_index;
      logic signed [COEFF_W-1:0]  coeff_value;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] filtered_sample;
      logic                       channel;
      logic                       clipped;
   } rsp_type;

   typedef struct packed {
      logic accept_sample;
      logic accept_coeff;
      logic issue;
      logic round;
      logic load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic pipe_busy;
      logic out_free;
   } ctrl_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_ROUND,
      ST_OUTPUT
   } state_type;

endpackage

[hdl/isfir_ram.sv]
// Generic simple dual-port RAM with registered read.
module isfir_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/isfir_ctrl.sv]
// Controller: handshake, tap sequencing and the tap-count register.
module isfir_ctrl #(
   parameter int MAX_TAPS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_kind,
   input  logic                             csr_write_enable,
   input  logic [isfir_pkg::TAPS_W-1:0]     csr_write_data,
   input  isfir_pkg::ctrl_status_type       status,
   output isfir_pkg::ctrl_cmd_type          cmd,
   output logic [$clog2(MAX_TAPS)-1:0]      tap_index
);
   import isfir_pkg::*;

   localparam int AW         = $clog2(MAX_TAPS);
   localparam int CW         = $clog2(MAX_TAPS + 1);
   localparam int TAPS_RESET = (TAPS_RESET_DEFAULT > MAX_TAPS) ? MAX_TAPS
                                                               : TAPS_RESET_DEFAULT;

   state_type         state_ff, state_in;
   logic [AW-1:0]     tap_ff, tap_in;
   logic [TAPS_W-1:0] taps_ff;
   logic [CW-1:0]     n_active;
   logic              accept;
   logic              last_tap;

   // 0 acts as 1, anything above the built size acts as the built size
   always_comb begin
      if (taps_ff == '0) begin
         n_active = CW'(1);
      end else if (32'(taps_ff) > MAX_TAPS) begin
         n_active = CW'(MAX_TAPS);
      end else begin
         n_active = CW'(taps_ff);
      end
   end

   assign last_tap  = (CW'(tap_ff) == n_active - CW'(1));
   assign req_stall = reset || (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign tap_index = tap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tap_ff   <= '0;
         taps_ff  <= TAPS_W'(TAPS_RESET);
      end else begin
         state_ff <= state_in;
         tap_ff   <= tap_in;
         if (csr_write_enable) begin
            taps_ff <= csr_write_data;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      tap_in   = tap_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            tap_in = '0;
            if (accept) begin
               if (req_kind == KIND_SAMPLE) begin
                  cmd.accept_sample = 1'b1;
                  state_in          = ST_RUN;
               end else begin
                  cmd.accept_coeff = 1'b1;
               end
            end
         end
         ST_RUN: begin
            cmd.issue = 1'b1;
            if (last_tap) begin
               state_in = ST_DRAIN;
            end else begin
               tap_in = tap_ff + AW'(1);
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            state_in  = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[hdl/isfir_datapath.sv]
// Datapath: delay-line and coefficient RAMs, MAC pipeline, rounding, output register.
module isfir_datapath #(
   parameter int MAX_TAPS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  isfir_pkg::req_type            req_data,
   input  isfir_pkg::ctrl_cmd_type       cmd,
   input  logic [$clog2(MAX_TAPS)-1:0]   tap_index,
   output isfir_pkg::ctrl_status_type    status,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output isfir_pkg::rsp_type            rsp_data
);
   import isfir_pkg::*;

   localparam int AW    = $clog2(MAX_TAPS);
   localparam int CW    = $clog2(MAX_TAPS + 1);
   localparam int ACC_W = PRODUCT_W + AW;
   localparam int QW    = ACC_W + 1 - FRAC_BITS;
   localparam logic [AW-1:0] PTR_LAST = AW'(MAX_TAPS - 1);
   localparam logic signed [QW-1:0] Q_MAX = QW'(SAT_MAX);
   localparam logic signed [QW-1:0] Q_MIN = QW'(SAT_MIN);

   // per-channel ring pointer and fill count (unfilled taps read as zero)
   logic [AW-1:0] wptr_ff [2];
   logic [CW-1:0] fill_ff [2];
   logic          next_ch_ff;

   logic          ch_ff;
   logic [AW-1:0] rd_ptr_ff;
   logic [CW-1:0] fill_cur_ff;

   logic [AW-1:0] new_ptr;
   logic [CW-1:0] new_fill;

   logic                       v1_ff, keep1_ff, v2_ff;
   logic signed [PRODUCT_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]     acc_ff;
   logic signed [QW-1:0]        q_ff;
   logic [ACC_W:0]              biased;

   logic [SAMPLE_W-1:0] delay_rd;
   logic [COEFF_W-1:0]  coeff_rd;
   logic signed [SAMPLE_W-1:0] term;
   logic                coeff_we;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   assign new_ptr  = (wptr_ff[next_ch_ff] == PTR_LAST) ? '0 : wptr_ff[next_ch_ff] + AW'(1);
   assign new_fill = (fill_ff[next_ch_ff] == CW'(MAX_TAPS)) ? fill_ff[next_ch_ff]
                                                             : fill_ff[next_ch_ff] + CW'(1);
   assign coeff_we = cmd.accept_coeff && (32'(req_data.coeff_index) < MAX_TAPS);

   isfir_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (2 * (2 ** AW))
   ) u_delay_ram (
      .clock   (clock),
      .wr_en   (cmd.accept_sample),
      .wr_addr ({next_ch_ff, new_ptr}),
      .wr_data (req_data.sample),
      .rd_addr ({ch_ff, rd_ptr_ff}),
      .rd_data (delay_rd)
   );

   isfir_ram #(
      .WIDTH (COEFF_W),
      .DEPTH (MAX_TAPS)
   ) u_coeff_ram (
      .clock   (clock),
      .wr_en   (coeff_we),
      .wr_addr (AW'(req_data.coeff_index)),
      .wr_data (req_data.coeff_value),
      .rd_addr (tap_index),
      .rd_data (coeff_rd)
   );

   // channel bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff[0] <= '0;
         wptr_ff[1] <= '0;
         fill_ff[0] <= '0;
         fill_ff[1] <= '0;
         next_ch_ff <= 1'b0;
      end else if (cmd.accept_sample) begin
         wptr_ff[next_ch_ff] <= new_ptr;
         fill_ff[next_ch_ff] <= new_fill;
         next_ch_ff          <= !next_ch_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept_sample) begin
         ch_ff       <= next_ch_ff;
         rd_ptr_ff   <= new_ptr;
         fill_cur_ff <= new_fill;
      end else if (cmd.issue) begin
         rd_ptr_ff <= (rd_ptr_ff == '0) ? PTR_LAST : rd_ptr_ff - AW'(1);
      end
   end

   // MAC pipeline: read, multiply, accumulate
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
      end
   end

   assign term = keep1_ff ? $signed(delay_rd) : '0;

   always_ff @(posedge clock) begin
      keep1_ff <= (CW'(tap_index) < fill_cur_ff);
      prod_ff  <= term * $signed(coeff_rd);
      if (cmd.accept_sample) begin
         acc_ff <= '0;
      end else if (v2_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   assign status.pipe_busy = v1_ff || v2_ff;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   // shift by FRAC_BITS, truncating toward zero
   assign biased = {acc_ff[ACC_W-1], acc_ff}
                 + (acc_ff[ACC_W-1] ? (ACC_W+1)'((1 << FRAC_BITS) - 1) : '0);

   always_ff @(posedge clock) begin
      if (cmd.round) begin
         q_ff <= $signed(biased[ACC_W:FRAC_BITS]);
      end
   end

   // saturation and output register
   always_comb begin
      rsp_in         = rsp_ff;
      rsp_in.channel = ch_ff;
      if (q_ff > Q_MAX) begin
         rsp_in.filtered_sample = SAMPLE_W'(SAT_MAX);
         rsp_in.clipped         = 1'b1;
      end else if (q_ff < Q_MIN) begin
         rsp_in.filtered_sample = SAMPLE_W'(SAT_MIN);
         rsp_in.clipped         = 1'b1;
      end else begin
         rsp_in.filtered_sample = q_ff[SAMPLE_W-1:0];
         rsp_in.clipped         = 1'b0;
      end
   end

   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[hdl/interleaved_stereo_fir_filter.sv]
// Top level of the interleaved stereo FIR filter: controller plus datapath.
// Per sample: the one MAC walks the N active taps, the pipeline drains, the sum is
//   rounded, then loaded into the output register that drives rsp_valid.
// A new sample is taken only once the last result is loaded; a coefficient write is
//   taken while idle and gives no result. A waiting result holds only the next load.
// Reset: sync, active high; clears channel order (left first), fill counts, tap count (64).
module interleaved_stereo_fir_filter #(
   parameter int MAX_TAPS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel: samples and coefficient writes
   input  logic                            req_valid,
   output logic                            req_stall,
   input  isfir_pkg::req_type              req_data,
   // response channel: one filtered sample per input sample
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output isfir_pkg::rsp_type              rsp_data,
   // tap count register
   input  logic                            csr_write_enable,
   input  logic [isfir_pkg::TAPS_W-1:0]    csr_write_data
);
   import isfir_pkg::*;

   ctrl_cmd_type                cmd;
   ctrl_status_type             status;
   logic [$clog2(MAX_TAPS)-1:0] tap_index;

   // Controller owns the handshake and walks tap_index 0..N-1 once per sample.
   isfir_ctrl #(
      .MAX_TAPS (MAX_TAPS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_data.kind),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .status           (status),
      .cmd              (cmd),
      .tap_index        (tap_index)
   );

   // Datapath: each channel's delay line is a ring buffer in RAM; taps beyond
   // the fill count read as zero, which stands in for the cleared history.
   // The output register lets the next transfer start while a result waits.
   isfir_datapath #(
      .MAX_TAPS (MAX_TAPS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .tap_index (tap_index),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
